@@ rtl/ptac_pkg.sv @@
package ptac_pkg;

    // Storage geometry and walk bound.
    localparam int STORE_DEPTH     = 256;
    localparam int DEF_MAX_ENTRIES = 256;
    localparam int WALK_LIMIT      = 256;
    localparam int IDX_W           = $clog2(STORE_DEPTH);
    localparam int COUNT_W         = IDX_W + 1;
    localparam int STEP_W          = $clog2(WALK_LIMIT);

    typedef enum logic [1:0] {
        KIND_ADD   = 2'd0,
        KIND_SET   = 2'd1,
        KIND_QUERY = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_BAD_INDEX = 2'd2,
        ST_LIMIT     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_WR2,
        S_WALK,
        S_DONE
    } t_state;

    // Strobes from the sequencer to the datapath.
    typedef struct packed {
        logic in_ready;
        logic capture;
        logic decode;
        logic second_wr;
        logic walk;
        logic finish;
    } t_ctrl;

    // Decisions from the datapath to the sequencer.
    typedef struct packed {
        logic dec_walk;
        logic dec_two;
        logic walk_end;
        logic out_free;
    } t_flags;

endpackage

@@ rtl/ptac_if.sv @@
interface ptac_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] entry;
    logic [7:0] other;
    logic       make_root;
    logic       parent_new;

    modport source (output valid, kind, entry, other, make_root, parent_new, input ready);
    modport sink   (input valid, kind, entry, other, make_root, parent_new, output ready);
endinterface

interface ptac_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] new_index;
    logic [7:0] parent_assigned;
    logic       is_ancestor;

    modport source (output valid, status, new_index, parent_assigned, is_ancestor, input ready);
    modport sink   (input valid, status, new_index, parent_assigned, is_ancestor, output ready);
endinterface

@@ rtl/ptac_ram.sv @@
module ptac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/ptac_seq.sv @@
module ptac_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    input  ptac_pkg::t_flags i_flags,
    output ptac_pkg::t_ctrl  o_ctrl
);

    ptac_pkg::t_state r_state;
    ptac_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ptac_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ptac_pkg::S_IDLE: begin
                if (i_req_valid) begin
                    n_state = ptac_pkg::S_DECODE;
                end
            end
            ptac_pkg::S_DECODE: begin
                if (i_flags.dec_walk) begin
                    n_state = ptac_pkg::S_WALK;
                end else if (i_flags.dec_two) begin
                    n_state = ptac_pkg::S_WR2;
                end else begin
                    n_state = ptac_pkg::S_DONE;
                end
            end
            ptac_pkg::S_WR2: begin
                n_state = ptac_pkg::S_DONE;
            end
            ptac_pkg::S_WALK: begin
                if (i_flags.walk_end) begin
                    n_state = ptac_pkg::S_DONE;
                end
            end
            ptac_pkg::S_DONE: begin
                if (i_flags.out_free) begin
                    n_state = ptac_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ptac_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ctrl = '0;
        case (r_state)
            ptac_pkg::S_IDLE: begin
                o_ctrl.in_ready = 1'b1;
                o_ctrl.capture  = i_req_valid;
            end
            ptac_pkg::S_DECODE: begin
                o_ctrl.decode = 1'b1;
            end
            ptac_pkg::S_WR2: begin
                o_ctrl.second_wr = 1'b1;
            end
            ptac_pkg::S_WALK: begin
                o_ctrl.walk = 1'b1;
            end
            ptac_pkg::S_DONE: begin
                o_ctrl.finish = i_flags.out_free;
            end
            default: begin
                o_ctrl = '0;
            end
        endcase
    end

endmodule

@@ rtl/parent_table_ancestor_check_top.sv @@
// Channel   Dir  Handshake      Payload
// i_req     in   valid / ready  kind, entry, other, make_root, parent_new
// o_res     out  valid / ready  status, new_index, parent_assigned, is_ancestor
//
// An add, a set, an unused kind or an item failing its checks runs from acceptance through
// decode to the done state, where its result is registered; an add that also allocates a
// root parent passes a second-write state first, as the table has one write port. A query
// with valid, differing indices walks the chain, at most 256 table reads, one chain step
// per cycle as the table's read port is registered. Reset clears the count and control only.
// A waiting result lets the next item run, but holds it in its final cycle until taken.
module parent_table_ancestor_check_top #(
    parameter int MAX_ENTRIES = ptac_pkg::DEF_MAX_ENTRIES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ptac_in_if.sink     i_req,
    ptac_out_if.source  o_res
);

    // Usable entries are bounded both by the parameter and by the table depth.
    localparam int CAPACITY = (MAX_ENTRIES < ptac_pkg::STORE_DEPTH) ?
                              MAX_ENTRIES : ptac_pkg::STORE_DEPTH;
    localparam int IW = ptac_pkg::IDX_W;
    localparam int CW = ptac_pkg::COUNT_W;
    localparam int SW = ptac_pkg::STEP_W;

    ptac_pkg::t_ctrl  w_ctrl;
    ptac_pkg::t_flags w_flags;

    // Captured item.
    ptac_pkg::t_kind  r_kind;
    logic [IW-1:0]    r_entry;
    logic [IW-1:0]    r_other;
    logic             r_make_root;
    logic             r_parent_new;

    // Allocation state and walk state.
    logic [CW-1:0]    r_count;
    logic [IW-1:0]    r_cur;
    logic [SW-1:0]    r_steps;

    // Pending result and output register.
    ptac_pkg::t_status r_res_status;
    logic [IW-1:0]     r_res_new;
    logic [IW-1:0]     r_res_par;
    logic              r_res_anc;
    logic              r_out_valid;
    ptac_pkg::t_status r_out_status;
    logic [IW-1:0]     r_out_new;
    logic [IW-1:0]     r_out_par;
    logic              r_out_anc;

    // Table port.
    logic          w_mem_we;
    logic [IW-1:0] w_mem_waddr;
    logic [IW-1:0] w_mem_wdata;
    logic [IW-1:0] w_mem_raddr;
    logic [IW-1:0] w_rdata;

    // Decode results.
    ptac_pkg::t_status n_status;
    logic [IW-1:0]     n_new;
    logic [IW-1:0]     n_par;
    logic              n_anc;
    logic              n_we;
    logic [IW-1:0]     n_waddr;
    logic [IW-1:0]     n_wdata;
    logic              n_count_inc;
    logic              n_walk;
    logic              n_two;

    logic w_room1;
    logic w_room2;
    logic w_entry_ok;
    logic w_other_ok;
    logic w_is_root;
    logic w_at_limit;
    logic w_hit;

    ptac_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_flags     (w_flags),
        .o_ctrl      (w_ctrl)
    );

    ptac_ram #(
        .WIDTH (IW),
        .DEPTH (ptac_pkg::STORE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_rdata)
    );

    // Bounds checks against the current fill.
    assign w_room1    = r_count < CW'(CAPACITY);
    assign w_room2    = ((CW+1)'(r_count) + (CW+1)'(2)) <= (CW+1)'(CAPACITY);
    assign w_entry_ok = CW'(r_entry) < r_count;
    assign w_other_ok = CW'(r_other) < r_count;

    always_comb begin
        n_status    = ptac_pkg::ST_OK;
        n_new       = '0;
        n_par       = '0;
        n_anc       = 1'b0;
        n_we        = 1'b0;
        n_waddr     = r_count[IW-1:0];
        n_wdata     = r_count[IW-1:0];
        n_count_inc = 1'b0;
        n_walk      = 1'b0;
        n_two       = 1'b0;
        case (r_kind)
            ptac_pkg::KIND_ADD: begin
                if (r_make_root) begin
                    // The new entry is a root: it points to itself.
                    if (!w_room1) begin
                        n_status = ptac_pkg::ST_FULL;
                    end else begin
                        n_we        = 1'b1;
                        n_count_inc = 1'b1;
                        n_new       = r_count[IW-1:0];
                        n_par       = r_count[IW-1:0];
                    end
                end else if (r_parent_new) begin
                    // Parent root goes in now, the child in the next cycle.
                    if (!w_room2) begin
                        n_status = ptac_pkg::ST_FULL;
                    end else begin
                        n_we        = 1'b1;
                        n_count_inc = 1'b1;
                        n_two       = 1'b1;
                        n_new       = r_count[IW-1:0] + IW'(1);
                        n_par       = r_count[IW-1:0];
                    end
                end else if (!w_other_ok) begin
                    n_status = ptac_pkg::ST_BAD_INDEX;
                end else if (!w_room1) begin
                    n_status = ptac_pkg::ST_FULL;
                end else begin
                    n_we        = 1'b1;
                    n_wdata     = r_other;
                    n_count_inc = 1'b1;
                    n_new       = r_count[IW-1:0];
                    n_par       = r_other;
                end
            end
            ptac_pkg::KIND_SET: begin
                if (!w_entry_ok || !w_other_ok) begin
                    n_status = ptac_pkg::ST_BAD_INDEX;
                end else begin
                    n_we    = 1'b1;
                    n_waddr = r_entry;
                    n_wdata = r_other;
                    n_par   = r_other;
                end
            end
            ptac_pkg::KIND_QUERY: begin
                if (!w_entry_ok || !w_other_ok) begin
                    n_status = ptac_pkg::ST_BAD_INDEX;
                end else if (r_entry == r_other) begin
                    n_anc = 1'b1;
                end else begin
                    n_walk = 1'b1;
                end
            end
            default: begin
                n_status = ptac_pkg::ST_OK;
            end
        endcase
    end

    // One chain step per cycle: the word read last cycle is the parent of r_cur.
    assign w_is_root  = w_rdata == r_cur;
    assign w_at_limit = r_steps == SW'(ptac_pkg::WALK_LIMIT - 1);
    assign w_hit      = w_rdata == r_other;

    // The second write of a new-parent add places the child, whose parent is the
    // entry written just before it.
    assign w_mem_we    = (w_ctrl.decode && n_we) || w_ctrl.second_wr;
    assign w_mem_waddr = w_ctrl.second_wr ? r_count[IW-1:0] : n_waddr;
    assign w_mem_wdata = w_ctrl.second_wr ? (r_count[IW-1:0] - IW'(1)) : n_wdata;
    assign w_mem_raddr = w_ctrl.walk ? w_rdata : r_entry;

    assign w_flags.dec_walk = n_walk;
    assign w_flags.dec_two  = n_two;
    assign w_flags.walk_end = w_is_root || w_at_limit || w_hit;
    assign w_flags.out_free = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if ((w_ctrl.decode && n_count_inc) || w_ctrl.second_wr) begin
                r_count <= r_count + CW'(1);
            end
            if (w_ctrl.finish) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.capture) begin
            r_kind       <= ptac_pkg::t_kind'(i_req.kind);
            r_entry      <= i_req.entry;
            r_other      <= i_req.other;
            r_make_root  <= i_req.make_root;
            r_parent_new <= i_req.parent_new;
        end
        if (w_ctrl.decode) begin
            r_res_status <= n_status;
            r_res_new    <= n_new;
            r_res_par    <= n_par;
            r_res_anc    <= n_anc;
            r_cur        <= r_entry;
            r_steps      <= '0;
        end
        if (w_ctrl.walk && !w_is_root) begin
            if (w_at_limit) begin
                r_res_status <= ptac_pkg::ST_LIMIT;
            end else if (w_hit) begin
                r_res_anc <= 1'b1;
            end else begin
                r_cur   <= w_rdata;
                r_steps <= r_steps + SW'(1);
            end
        end
        if (w_ctrl.finish) begin
            r_out_status <= r_res_status;
            r_out_new    <= r_res_new;
            r_out_par    <= r_res_par;
            r_out_anc    <= r_res_anc;
        end
    end

    assign i_req.ready           = w_ctrl.in_ready;
    assign o_res.valid           = r_out_valid;
    assign o_res.status          = r_out_status;
    assign o_res.new_index       = r_out_new;
    assign o_res.parent_assigned = r_out_par;
    assign o_res.is_ancestor     = r_out_anc;

    // A chain walk only reads the table.
    a_walk_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.walk |-> !w_mem_we)
        else $error("table written during a chain walk");

    // The fill never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // Each step of a walk that goes on counts one more table read.
    a_step_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctrl.walk && !w_flags.walk_end) |=> (r_steps == SW'($past(r_steps) + SW'(1))))
        else $error("walk step counter out of sequence");

    // Only an add changes the fill.
    a_count_add_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_count != $past(r_count))) |->
        ($past(r_kind) == ptac_pkg::KIND_ADD))
        else $error("entry count changed by an item that is not an add");

endmodule
